// File: src/n2w_pkg.sv
`default_nettype none

package n2w_pkg;

    // Field widths
    localparam int VALUE_W  = 31;
    localparam int CODE_W   = 5;
    localparam int DIGITS   = 10;            // decimal digits for a 31-bit value
    localparam int BCD_W    = 4 * DIGITS;
    localparam int GRP_W    = 48;            // BCD padded to four 3-digit groups
    localparam int CNT_W    = 5;             // shift counter, counts 0..VALUE_W-1

    // Word codes
    localparam logic [CODE_W-1:0] TOK_ZERO     = 5'd0;
    localparam logic [CODE_W-1:0] TOK_TEN      = 5'd10;
    localparam logic [CODE_W-1:0] TOK_TENS0    = 5'd18;
    localparam logic [CODE_W-1:0] TOK_HUNDRED  = 5'd28;
    localparam logic [CODE_W-1:0] TOK_BILLION  = 5'd31;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_HUND,
        ST_HWORD,
        ST_TENS,
        ST_ONES,
        ST_SCALE,
        ST_FLUSH
    } st_t;

    // Double-dabble digit correction
    function automatic logic [3:0] add3(input logic [3:0] d);
        logic [3:0] r;
        r = (d >= 4'd5) ? d + 4'd3 : d;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/n2w_dabble.sv
`default_nettype none

module n2w_dabble (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         load,
    input  wire logic [n2w_pkg::VALUE_W-1:0]  value,
    output logic                              done,
    output logic [n2w_pkg::BCD_W-1:0]         bcd
);
    import n2w_pkg::*;

    logic [VALUE_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [BCD_W-1:0]   bcd_adj;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               run_reg, run_next;
    logic               done_reg, done_next;

    // Per-digit add-3 correction, then shift one binary bit in
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            bcd_adj[4*i +: 4] = add3(bcd_reg[4*i +: 4]);
        end
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (load)
        begin
            bin_next = value;
            bcd_next = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
            bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(VALUE_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath shift registers
    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

`default_nettype wire

// File: src/number_to_word_tokens.sv
`default_nettype none

// Spells a 31-bit unsigned value as a run of English word codes.
// Input: value is taken at a rising edge with start high and busy low.
// busy stays high until the last word of the run has been issued.
// Output: one word per cycle at most, flagged by word_valid for exactly one
// cycle with word_code and last_word; last_word marks the end of the run.
// The receiver cannot stall; words are issued as they are produced.
// Operation: the value is converted to BCD one bit per cycle, then the four
// 3-digit groups are walked by a sequencer at four steps per group, five
// where the group has a hundreds digit (at most 19 steps, as the billions
// group never has one), then the held final word is flushed. Busy drops
// with the last word, so a new number is taken only once every word of the
// last one has been issued. A one-word hold register keeps each word until
// the next one is produced or the run is flushed, so the last one can be
// flagged.
// Reset clears the sequencer, the converter control and word_valid; no
// clearing pass is needed.
module number_to_word_tokens (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [n2w_pkg::VALUE_W-1:0]  value,
    output logic                              word_valid,
    output logic [n2w_pkg::CODE_W-1:0]        word_code,
    output logic                              last_word
);
    import n2w_pkg::*;

    st_t                 st_reg, st_next;
    logic [GRP_W-1:0]    grp_reg, grp_next;
    logic [1:0]          gidx_reg, gidx_next;
    logic                pend_valid_reg;
    logic [CODE_W-1:0]   pend_code_reg;
    logic                word_valid_reg;
    logic [CODE_W-1:0]   word_code_reg;
    logic                last_word_reg;

    logic                conv_load;
    logic                conv_done;
    logic [BCD_W-1:0]    conv_bcd;
    logic                tok_en;
    logic [CODE_W-1:0]   tok_code;
    logic                out_en;
    logic                out_last;
    logic [3:0]          dig_h, dig_t, dig_o;

    n2w_dabble u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (conv_load),
        .value (value),
        .done  (conv_done),
        .bcd   (conv_bcd)
    );

    // Digits of the current group sit at the top of the group shifter
    assign dig_h = grp_reg[GRP_W-1 -: 4];
    assign dig_t = grp_reg[GRP_W-5 -: 4];
    assign dig_o = grp_reg[GRP_W-9 -: 4];

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    // Sequencer: next state and word generation
    always_comb
    begin
        st_next   = st_reg;
        grp_next  = grp_reg;
        gidx_next = gidx_reg;
        conv_load = 1'b0;
        tok_en    = 1'b0;
        tok_code  = TOK_ZERO;
        out_en    = 1'b0;
        out_last  = 1'b0;
        case (st_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    conv_load = 1'b1;
                    st_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (conv_done)
                begin
                    grp_next  = {(GRP_W - BCD_W)'(0), conv_bcd};
                    gidx_next = '0;
                    st_next   = ST_HUND;
                end
            end
            ST_HUND:
            begin
                if (gidx_reg == 2'd0 && grp_reg == '0)
                begin
                    // whole value is zero
                    tok_en   = 1'b1;
                    tok_code = TOK_ZERO;
                    st_next  = ST_FLUSH;
                end
                else if (dig_h != 4'd0)
                begin
                    tok_en   = 1'b1;
                    tok_code = {1'b0, dig_h};
                    st_next  = ST_HWORD;
                end
                else
                begin
                    st_next = ST_TENS;
                end
            end
            ST_HWORD:
            begin
                tok_en   = 1'b1;
                tok_code = TOK_HUNDRED;
                st_next  = ST_TENS;
            end
            ST_TENS:
            begin
                if (dig_t >= 4'd2)
                begin
                    tok_en   = 1'b1;
                    tok_code = TOK_TENS0 + {1'b0, dig_t};
                end
                else if (dig_t != 4'd0)
                begin
                    // ten to nineteen
                    tok_en   = 1'b1;
                    tok_code = TOK_TEN + {1'b0, dig_o};
                end
                else if (dig_o != 4'd0)
                begin
                    tok_en   = 1'b1;
                    tok_code = {1'b0, dig_o};
                end
                st_next = ST_ONES;
            end
            ST_ONES:
            begin
                if (dig_t >= 4'd2 && dig_o != 4'd0)
                begin
                    tok_en   = 1'b1;
                    tok_code = {1'b0, dig_o};
                end
                st_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                if (grp_reg[GRP_W-1 -: 12] != '0 && gidx_reg != 2'd3)
                begin
                    tok_en   = 1'b1;
                    tok_code = TOK_BILLION - {3'b0, gidx_reg};
                end
                if (gidx_reg == 2'd3)
                begin
                    st_next = ST_FLUSH;
                end
                else
                begin
                    gidx_next = gidx_reg + 2'd1;
                    grp_next  = {grp_reg[GRP_W-13:0], 12'b0};
                    st_next   = ST_HUND;
                end
            end
            ST_FLUSH:
            begin
                out_en   = 1'b1;
                out_last = 1'b1;
                st_next  = ST_IDLE;
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
        // a new word pushes out the held one
        if (tok_en && pend_valid_reg)
        begin
            out_en = 1'b1;
        end
    end

    // Hold register and output word, control part
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            word_valid_reg <= 1'b0;
            gidx_reg       <= '0;
        end
        else
        begin
            gidx_reg       <= gidx_next;
            word_valid_reg <= out_en;
            if (tok_en)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (st_reg == ST_FLUSH)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        grp_reg <= grp_next;
        if (tok_en)
        begin
            pend_code_reg <= tok_code;
        end
        if (out_en)
        begin
            word_code_reg <= pend_code_reg;
            last_word_reg <= out_last;
        end
    end

    assign busy       = (st_reg != ST_IDLE);
    assign word_valid = word_valid_reg;
    assign word_code  = word_code_reg;
    assign last_word  = last_word_reg;

endmodule

`default_nettype wire

// File: src/n2w_check.sv
`default_nettype none

module n2w_check (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic                         busy,
    input  wire logic                         word_valid,
    input  wire logic [n2w_pkg::CODE_W-1:0]   word_code,
    input  wire logic                         last_word
);
    import n2w_pkg::*;

    // An accepted number makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    // No word right after accept: conversion comes first
    a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> !word_valid)
        else $error("word issued right after accept");

    // More words follow a word that is not the last
    a_more_words: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && !last_word |=> busy)
        else $error("run ended without a last word");

    // The last word frees the block
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && last_word |-> !busy)
        else $error("busy after last word");

    // Zero only ever stands alone
    a_zero_alone: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && word_code == TOK_ZERO |-> last_word)
        else $error("zero word inside a run");

endmodule

bind number_to_word_tokens n2w_check u_n2w_check (.*);

`default_nettype wire

// File: tb/sv/number_to_word_tokens_tb.sv
`timescale 1ns / 100ps

module number_to_word_tokens_tb;

    import n2w_pkg::*;

    localparam int LIMIT      = 200000;  // cycles before the run is declared hung
    localparam int N_RANDOM   = 95;
    localparam int DRAIN_CYC  = 80;      // longer than one full run of words
    localparam int RUN_MAX    = 16;

    // Word codes as the block numbers them
    typedef enum logic [CODE_W-1:0] {
        W_ZERO, W_ONE, W_TWO, W_THREE, W_FOUR, W_FIVE, W_SIX, W_SEVEN, W_EIGHT,
        W_NINE, W_TEN, W_ELEVEN, W_TWELVE, W_THIRTEEN, W_FOURTEEN, W_FIFTEEN,
        W_SIXTEEN, W_SEVENTEEN, W_EIGHTEEN, W_NINETEEN,
        W_TWENTY, W_THIRTY, W_FORTY, W_FIFTY, W_SIXTY, W_SEVENTY, W_EIGHTY,
        W_NINETY, W_HUNDRED, W_THOUSAND, W_MILLION, W_BILLION
    } word_e;

    typedef word_e run_t [$];

    typedef struct packed {
        word_e code;
        logic  last;
    } word_t;

    // One stimulus row: the value and, for a few rows, the words typed in by hand
    typedef struct packed {
        logic [VALUE_W-1:0]         value;
        logic [4:0]                 n_typed;
        logic [RUN_MAX*CODE_W-1:0]  typed;    // first word in the top bits
    } row_t;

    localparam int DIR_N = 25;
    localparam row_t DIRECTED [DIR_N] = '{
        '{31'd0,          5'd1,  {W_ZERO, 75'd0}},
        '{31'd1,          5'd1,  {W_ONE, 75'd0}},
        '{31'd9,          5'd0,  80'd0},
        '{31'd10,         5'd0,  80'd0},
        '{31'd11,         5'd0,  80'd0},
        '{31'd15,         5'd0,  80'd0},
        '{31'd19,         5'd0,  80'd0},
        '{31'd20,         5'd0,  80'd0},
        '{31'd21,         5'd0,  80'd0},
        '{31'd45,         5'd0,  80'd0},
        '{31'd99,         5'd0,  80'd0},
        '{31'd100,        5'd2,  {W_ONE, W_HUNDRED, 70'd0}},
        '{31'd101,        5'd0,  80'd0},
        '{31'd110,        5'd0,  80'd0},
        '{31'd999,        5'd0,  80'd0},
        '{31'd1000,       5'd0,  80'd0},
        '{31'd1001,       5'd0,  80'd0},
        '{31'd12000,      5'd0,  80'd0},
        '{31'd1000000,    5'd0,  80'd0},
        '{31'd7000019,    5'd0,  80'd0},
        '{31'd1000000000, 5'd2,  {W_ONE, W_BILLION, 70'd0}},
        '{31'd2000000000, 5'd2,  {W_TWO, W_BILLION, 70'd0}},
        // largest value, spelled out in sixteen words
        '{31'd2147483647, 5'd16, {W_TWO, W_BILLION, W_ONE, W_HUNDRED, W_FORTY, W_SEVEN,
                                  W_MILLION, W_FOUR, W_HUNDRED, W_EIGHTY, W_THREE,
                                  W_THOUSAND, W_SIX, W_HUNDRED, W_FORTY, W_SEVEN}},
        '{31'd999999999,  5'd0,  80'd0},
        '{31'd1073741824, 5'd0,  80'd0}
    };

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [VALUE_W-1:0]  value = '0;
    logic                busy;
    logic                word_valid;
    logic [CODE_W-1:0]   word_code;
    logic                last_word;

    row_t   stim_q [$];
    word_t  words_due [$];
    int     stim_idx = 0;
    int     cur_row = 0;
    int     pause_at = DIR_N;
    int     burst_left = 1;
    int     gap_left = 0;
    int     errors = 0;
    int     cycles = 0;
    int     words_checked = 0;
    int     longest_run = 0;

    number_to_word_tokens dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .value      (value),
        .word_valid (word_valid),
        .word_code  (word_code),
        .last_word  (last_word)
    );

    always #5 clk = ~clk;

    // Words for a value: base-1000 groups, most significant first
    function automatic run_t spell_number(input logic [VALUE_W-1:0] v);
        int unsigned scale_div [4] = '{1000000000, 1000000, 1000, 1};
        word_e       scale_word [3] = '{W_BILLION, W_MILLION, W_THOUSAND};
        run_t        run;
        int unsigned n, grp, rest;
        n = v;
        if (n == 0)
            run.insert(run.size(), W_ZERO);
        for (int g = 0; g < 4; g++)
        begin
            grp = (n / scale_div[g]) % 1000;
            rest = grp % 100;
            if (grp == 0)
                continue;
            if (grp >= 100)
            begin
                run.insert(run.size(), word_e'(grp / 100));
                run.insert(run.size(), W_HUNDRED);
            end
            if (rest >= 20)
            begin
                run.insert(run.size(), word_e'(W_TWENTY + rest / 10 - 2));
                if (rest % 10 != 0)
                    run.insert(run.size(), word_e'(rest % 10));
            end
            else if (rest != 0)
                run.insert(run.size(), word_e'(rest));
            if (g < 3)
                run.insert(run.size(), scale_word[g]);
        end
        return run;
    endfunction

    // Random value, mostly built group by group so zero groups and scale words show up
    function automatic logic [VALUE_W-1:0] random_value();
        longint v;
        int unsigned grp [3];
        case ($urandom_range(0, 3))
            0: v = $urandom() & 32'h7FFF_FFFF;
            1: v = $urandom_range(0, 999);
            default:
            begin
                foreach (grp[i])
                    grp[i] = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 999);
                v = longint'($urandom_range(0, 2)) * 1000000000 + grp[0] * 1000000
                    + grp[1] * 1000 + grp[2];
                if (v > 2147483647)
                    v = v - 1000000000;
            end
        endcase
        return v[VALUE_W-1:0];
    endfunction

    // Check words, take accepted numbers, drive the next one
    always @(posedge clk)
    begin
        word_t due;
        run_t  run;
        row_t  row;
        bit    hold;
        if (rst_n)
        begin
            // words coming out
            if (word_valid)
            begin
                words_checked++;
                if (words_due.size() == 0)
                begin
                    $error("unexpected word: word_code %0d last_word %0b", word_code, last_word);
                    errors++;
                end
                else
                begin
                    due = words_due.pop_front();
                    if (word_code !== due.code)
                    begin
                        $error("word_code: expected %0d, got %0d", due.code, word_code);
                        errors++;
                    end
                    if (last_word !== due.last)
                    begin
                        $error("last_word: expected %0b, got %0b", due.last, last_word);
                        errors++;
                    end
                end
            end

            // number accepted: queue its words
            if (start && !busy)
            begin
                row = stim_q[cur_row];
                run.delete();
                if (row.n_typed != 0)
                begin
                    for (int k = 0; k < row.n_typed; k++)
                        run.insert(run.size(),
                                   word_e'(row.typed[RUN_MAX*CODE_W-1-CODE_W*k -: CODE_W]));
                end
                else
                    run = spell_number(row.value);
                foreach (run[i])
                    words_due.insert(words_due.size(), '{run[i], i == run.size() - 1});
                if (run.size() > longest_run)
                    longest_run = run.size();
            end

            // next number, in bursts with gaps; drain fully at the pause points
            if (!start || !busy)
            begin
                hold = 1'b0;
                if (stim_idx == pause_at)
                begin
                    if (words_due.size() != 0)
                        hold = 1'b1;
                    else
                        pause_at = (pause_at == DIR_N) ? DIR_N + N_RANDOM / 2 : -1;
                end
                if (hold || stim_idx >= stim_q.size())
                    start <= 1'b0;
                else if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else
                begin
                    cur_row = stim_idx;
                    value <= stim_q[stim_idx].value;
                    start <= 1'b1;
                    stim_idx++;
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 8);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 70);
                    end
                end
            end
        end
    end

    // Hang guard
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still due", cycles, words_due.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        foreach (DIRECTED[i])
            stim_q.insert(stim_q.size(), DIRECTED[i]);
        repeat (N_RANDOM)
            stim_q.insert(stim_q.size(), '{random_value(), 5'd0, 80'd0});

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (stim_idx < stim_q.size() || start)
            @(negedge clk);
        while (words_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYC) @(negedge clk);

        $display("spelled %0d numbers (%0d directed, %0d random), %0d words checked",
                 stim_q.size(), DIR_N, N_RANDOM, words_checked);
        $display("longest run %0d words, %0d mismatches", longest_run, errors);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
